@@ src/intel_hex_record_loader_top_macros.svh @@
// Assertion macros shared by the HEX loader RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef INTEL_HEX_RECORD_LOADER_TOP_MACROS_SVH
`define INTEL_HEX_RECORD_LOADER_TOP_MACROS_SVH
`ifndef SYNTH
// Expression must hold at every edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("check failed: always");
// Antecedent implies consequent in the same cycle.
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: implication");
// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: next cycle");
`else
`define CHK_ALWAYS(lbl, clk, rst, expr)
`define CHK_IMPL(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ src/ihex_pkg.sv @@
// Shared types and constants for the HEX record loader.
// No dependencies; imported by front, queue, back and top.
`default_nettype none
package ihex_pkg;

  // One classified character word handed from front to back.
  typedef struct packed {
    logic       line_end;
    logic       is_colon;
    logic       hex_ok;
    logic [3:0] digit;
  } tok_t;

  // Line status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SKIP      = 3'd1;
  localparam logic [2:0] ST_BAD_DIGIT = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_CSUM      = 3'd4;
  localparam logic [2:0] ST_WRAP      = 3'd5;
  localparam logic [2:0] ST_AFTER_END = 3'd6;

  // Record types
  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_ELA  = 8'h04;
  localparam logic [7:0] REC_SLA  = 8'h05;

  localparam logic [7:0]  CH_COLON      = 8'h3A;
  localparam logic [31:0] RUN_ADDR_INIT = 32'h0000_FFFF;

endpackage
`default_nettype wire

@@ src/ihex_front.sv @@
// Front end: accepts characters and classifies them into tokens.
// Depends on ihex_pkg.
`default_nettype none
module ihex_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    ch,
  input  logic          line_end,
  input  logic          q_full,
  output logic          push,
  output ihex_pkg::tok_t push_tok
);
  import ihex_pkg::*;

  logic [7:0] up;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Fold lower case onto upper case before the digit decode.
  assign up = (ch >= 8'h61 && ch <= 8'h7A) ? (ch & 8'hDF) : ch;

  always_comb begin
    push_tok.line_end = line_end;
    push_tok.is_colon = (ch == CH_COLON);
    push_tok.hex_ok   = 1'b0;
    push_tok.digit    = 4'd0;
    if (up >= 8'h30 && up <= 8'h39) begin
      push_tok.hex_ok = 1'b1;
      push_tok.digit  = up[3:0];
    end else if (up >= 8'h41 && up <= 8'h46) begin
      push_tok.hex_ok = 1'b1;
      push_tok.digit  = up[3:0] + 4'd9;
    end
  end

endmodule
`default_nettype wire

@@ src/ihex_fifo.sv @@
// Short token queue between front and back.
// Depends on ihex_pkg and the assertion macro header.
`default_nettype none
`include "intel_hex_record_loader_top_macros.svh"
module ihex_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ihex_pkg::tok_t push_tok,
  output logic           full,
  input  logic           pop,
  output ihex_pkg::tok_t pop_tok,
  output logic           not_empty
);
  import ihex_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_tok   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `CHK_ALWAYS(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `CHK_IMPL(a_pop_nonempty, clk, rst, pop, not_empty)
  `CHK_NEXT(a_count_grow, clk, rst, push && !pop, count == $past(count) + CW'(1))

endmodule
`default_nettype wire

@@ src/ihex_back.sv @@
// Back end: record parser state, checksum, address tracking, result register.
// Depends on ihex_pkg and the assertion macro header.
`default_nettype none
`include "intel_hex_record_loader_top_macros.svh"
module ihex_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           tok_valid,
  input  ihex_pkg::tok_t tok,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           kind,
  output logic [7:0]     data_byte,
  output logic [31:0]    abs_address,
  output logic [2:0]     status,
  output logic [7:0]     rec_type,
  output logic [7:0]     rec_count,
  output logic           new_section
);
  import ihex_pkg::*;

  // Line state
  logic [9:0]  char_pos,    char_pos_next;
  logic [15:0] nibble_acc,  nibble_acc_next;
  logic [7:0]  sum_acc,     sum_acc_next;
  logic [7:0]  count_field, count_field_next;
  logic [15:0] addr_field,  addr_field_next;
  logic [7:0]  type_field,  type_field_next;
  logic [31:0] first_bytes, first_bytes_next;
  logic [2:0]  line_error,  line_error_next;
  // Persistent state
  logic [31:0] run_address, run_address_next;
  logic        end_seen,    end_seen_next;

  // Result of this step
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_byte;
  logic [31:0] res_addr;
  logic [2:0]  res_status;
  logic [7:0]  res_type;
  logic [7:0]  res_count;
  logic        res_newsec;

  logic        step;
  logic [9:0]  last_pos;
  logic [15:0] nib_new;
  logic [8:0]  data_off;
  logic [7:0]  idx;
  logic [16:0] wrap_sum;
  logic        low_zero;
  logic [15:0] new_upper;
  logic [31:0] sect_base;
  logic        sect_new;

  assign step = tok_valid && (!out_valid || out_ready);
  assign pop  = step;

  assign last_pos  = 10'd10 + {1'b0, count_field, 1'b0};
  assign nib_new   = {nibble_acc[11:0], tok.digit};
  assign data_off  = char_pos[8:0] - 9'd10;
  assign idx       = data_off[8:1];
  assign sect_base = {run_address[31:16], addr_field};
  assign sect_new  = (run_address[15:0] != addr_field);
  assign wrap_sum  = {1'b0, addr_field} + {9'd0, count_field};
  assign low_zero  = (wrap_sum[15:0] == 16'd0);
  // Carry into the upper half, minus one page when the low half lands on zero.
  assign new_upper = run_address[31:16] + {15'd0, wrap_sum[16]} - {15'd0, low_zero};

  always_comb begin
    char_pos_next    = char_pos;
    nibble_acc_next  = nibble_acc;
    sum_acc_next     = sum_acc;
    count_field_next = count_field;
    addr_field_next  = addr_field;
    type_field_next  = type_field;
    first_bytes_next = first_bytes;
    line_error_next  = line_error;
    run_address_next = run_address;
    end_seen_next    = end_seen;
    res_valid  = 1'b0;
    res_kind   = 1'b0;
    res_byte   = 8'd0;
    res_addr   = 32'd0;
    res_status = ST_OK;
    res_type   = type_field;
    res_count  = count_field;
    res_newsec = 1'b0;

    if (step) begin
      if (tok.line_end) begin
        res_valid = 1'b1;
        res_kind  = 1'b1;
        if (end_seen) begin
          res_status = ST_AFTER_END;
          res_type   = 8'd0;
          res_count  = 8'd0;
        end else if (line_error != ST_OK) begin
          res_status = line_error;
        end else if (char_pos == 10'd0) begin
          res_status = ST_SKIP;
        end else if (char_pos <= last_pos) begin
          res_status = ST_SHORT;
        end else if (sum_acc != 8'd0) begin
          res_status = ST_CSUM;
        end else if (type_field == REC_DATA) begin
          if (wrap_sum > 17'h1_0000) begin
            res_status = ST_WRAP;
          end else begin
            res_addr         = sect_base;
            res_newsec       = sect_new;
            run_address_next = {new_upper, wrap_sum[15:0]};
          end
        end else begin
          case (type_field)
            REC_EOF: begin
              end_seen_next = 1'b1;
            end
            REC_ELA: begin
              res_addr         = {first_bytes[31:16], 16'd0};
              run_address_next = {first_bytes[31:16], run_address[15:0]};
            end
            REC_SLA: begin
              res_addr = first_bytes;
            end
            default: begin
            end
          endcase
        end
        char_pos_next    = 10'd0;
        nibble_acc_next  = 16'd0;
        sum_acc_next     = 8'd0;
        count_field_next = 8'd0;
        addr_field_next  = 16'd0;
        type_field_next  = 8'd0;
        first_bytes_next = 32'd0;
        line_error_next  = ST_OK;
      end else begin
        if (char_pos != 10'h3FF) begin
          char_pos_next = char_pos + 10'd1;
        end
        if (!end_seen && line_error == ST_OK) begin
          if (char_pos == 10'd0) begin
            if (!tok.is_colon) begin
              line_error_next = ST_SKIP;
            end
          end else if (char_pos <= last_pos) begin
            if (!tok.hex_ok) begin
              line_error_next = ST_BAD_DIGIT;
            end else begin
              nibble_acc_next = nib_new;
              if (!char_pos[0]) begin
                sum_acc_next = sum_acc + nib_new[7:0];
                if (char_pos == 10'd2) begin
                  count_field_next = nib_new[7:0];
                end else if (char_pos == 10'd6) begin
                  addr_field_next = nib_new;
                end else if (char_pos == 10'd8) begin
                  type_field_next = nib_new[7:0];
                end else if (char_pos >= 10'd10 && char_pos <= last_pos - 10'd2) begin
                  // First four data bytes are kept for address records.
                  if (idx[7:2] == 6'd0) begin
                    case (idx[1:0])
                      2'd0:    first_bytes_next[31:24] = nib_new[7:0];
                      2'd1:    first_bytes_next[23:16] = nib_new[7:0];
                      2'd2:    first_bytes_next[15:8]  = nib_new[7:0];
                      default: first_bytes_next[7:0]   = nib_new[7:0];
                    endcase
                  end
                  if (type_field == REC_DATA) begin
                    res_valid  = 1'b1;
                    res_byte   = nib_new[7:0];
                    res_addr   = sect_base + {24'd0, idx};
                    res_newsec = sect_new;
                  end
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_pos    <= 10'd0;
      nibble_acc  <= 16'd0;
      sum_acc     <= 8'd0;
      count_field <= 8'd0;
      addr_field  <= 16'd0;
      type_field  <= 8'd0;
      first_bytes <= 32'd0;
      line_error  <= ST_OK;
      run_address <= RUN_ADDR_INIT;
      end_seen    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      char_pos    <= char_pos_next;
      nibble_acc  <= nibble_acc_next;
      sum_acc     <= sum_acc_next;
      count_field <= count_field_next;
      addr_field  <= addr_field_next;
      type_field  <= type_field_next;
      first_bytes <= first_bytes_next;
      line_error  <= line_error_next;
      run_address <= run_address_next;
      end_seen    <= end_seen_next;
      if (step) begin
        out_valid <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      kind        <= res_kind;
      data_byte   <= res_byte;
      abs_address <= res_addr;
      status      <= res_status;
      rec_type    <= res_type;
      rec_count   <= res_count;
      new_section <= res_newsec;
    end
  end

  `CHK_ALWAYS(a_err_code, clk, rst,
    line_error == ST_OK || line_error == ST_SKIP || line_error == ST_BAD_DIGIT)
  `CHK_IMPL(a_data_ok, clk, rst, out_valid && !kind, status == ST_OK)
  `CHK_IMPL(a_data_no_end, clk, rst, step && res_valid && !res_kind, !end_seen)

endmodule
`default_nettype wire

@@ src/intel_hex_record_loader_top.sv @@
// Top level of the HEX record loader: front classifier, token queue, parser back end.
// Depends on ihex_pkg, ihex_front, ihex_fifo, ihex_back.
//
// Usage:
//  - Input channel (in_valid/in_ready): one text character word per handshake,
//    ch plus line_end; line_end=1 closes the current line and ch is ignored.
//  - Output channel (out_valid/out_ready): kind=0 words carry each data byte of
//    a type 00 record with its absolute address as soon as its pair is parsed;
//    kind=1 is the single status word per line (ok, skipped, bad digit, short,
//    checksum, page wrap, after end).
//  - Throughput: one character per cycle sustained while out_ready stays high. The
//    back end parser updates its line state once per character; the queue and
//    output register decouple the two channels.
//  - Order: an accepted character is written into the queue at the accepting edge;
//    the parser step then loads its result into the output register, where it is taken.
//  - Stall: when out_valid is high and out_ready low the output register holds; the parser stops,
//    the queue fills, and in_ready drops once QUEUE_DEPTH words are waiting.
//  - Reset (rst, synchronous): empties queue and output, clears line state,
//    sets the running address to 0x0000FFFF and clears the end-of-file flag.
`default_nettype none
module intel_hex_record_loader_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        line_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  data_byte,
  output logic [31:0] abs_address,
  output logic [2:0]  status,
  output logic [7:0]  rec_type,
  output logic [7:0]  rec_count,
  output logic        new_section
);
  import ihex_pkg::*;

  tok_t push_tok;
  tok_t pop_tok;
  logic push;
  logic pop;
  logic q_full;
  logic q_not_empty;

  // Classify each character on acceptance.
  ihex_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .line_end (line_end),
    .q_full   (q_full),
    .push     (push),
    .push_tok (push_tok)
  );

  // Token queue lets the input keep flowing while the output stalls.
  ihex_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_tok  (push_tok),
    .full      (q_full),
    .pop       (pop),
    .pop_tok   (pop_tok),
    .not_empty (q_not_empty)
  );

  // Record parser and result register.
  ihex_back u_back (
    .clk         (clk),
    .rst         (rst),
    .tok_valid   (q_not_empty),
    .tok         (pop_tok),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .data_byte   (data_byte),
    .abs_address (abs_address),
    .status      (status),
    .rec_type    (rec_type),
    .rec_count   (rec_count),
    .new_section (new_section)
  );

endmodule
`default_nettype wire
